/* sv/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the hsv to rgb pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  // fixed-point formats
  localparam int unsigned HueW    = 16;  // raw hue, signed
  localparam int unsigned HueCW   = 15;  // clamped hue, unsigned
  localparam int unsigned RemW    = 12;  // remainder within one sector
  localparam int unsigned SvW     = 9;   // saturation and value
  localparam int unsigned NumW    = 20;  // 3840*256 minus a product
  localparam int unsigned VpW     = 17;  // v*(256-s)
  localparam int unsigned MulW    = 28;  // v*num
  localparam int unsigned ChW     = 8;   // one output channel

  localparam logic [HueCW-1:0] HueSector = 15'd3840;
  localparam logic [HueCW-1:0] HueMax    = 15'd22976;
  localparam logic [SvW-1:0]   Unit      = 9'd256;
  localparam logic [NumW-1:0]  FullNum   = 20'd983040;  // 3840*256
  localparam logic [ChW-1:0]   AlphaOne  = 8'd255;

  // the 60 degree sector of the hue circle
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

  // after clamp and sector split
  typedef struct packed {
    sector_e           sector;
    logic [RemW-1:0]   rem;
    logic [SvW-1:0]    sat;
    logic [SvW-1:0]    val;
  } split_t;

  // after the scaling products, ready for the channel mix
  typedef struct packed {
    sector_e           sector;
    logic [MulW-1:0]   mul_q;
    logic [MulW-1:0]   mul_t;
    logic [ChW-1:0]    ch_v;
    logic [ChW-1:0]    ch_p;
  } scaled_t;

endpackage

`default_nettype wire

/* sv/hsv2rgb_if.sv */
// ----------------------------------------------------------------------------
// hsv2rgb channel interfaces
// Valid/ready channels for hsv input pixels and rgba output pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hue;
  logic [8:0]         saturation;
  logic [8:0]         brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface rgba_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

`default_nettype wire

/* sv/hsv2rgb_split.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_split
// First stage: clamps the inputs and splits hue into sector and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_split (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  valid_i,
  output logic                                 ready_o,
  input  wire signed [hsv2rgb_pkg::HueW-1:0]   hue_i,
  input  wire        [hsv2rgb_pkg::SvW-1:0]    sat_i,
  input  wire        [hsv2rgb_pkg::SvW-1:0]    val_i,
  output logic                                 valid_o,
  input  wire                                  ready_i,
  output hsv2rgb_pkg::split_t                  data_o
);

  logic                                valid_q;
  hsv2rgb_pkg::split_t                 data_d, data_q;
  logic [hsv2rgb_pkg::HueCW-1:0]       hue_c;
  logic [hsv2rgb_pkg::HueCW-1:0]       base;
  logic [hsv2rgb_pkg::HueCW-1:0]       rem_w;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    // clamp hue to 0..359 degrees
    if (hue_i[hsv2rgb_pkg::HueW-1]) begin
      hue_c = '0;
    end else if (hue_i[hsv2rgb_pkg::HueCW-1:0] > hsv2rgb_pkg::HueMax) begin
      hue_c = hsv2rgb_pkg::HueMax;
    end else begin
      hue_c = hue_i[hsv2rgb_pkg::HueCW-1:0];
    end

    // sector by compare against multiples of 60 degrees
    if (hue_c >= 15'(5 * hsv2rgb_pkg::HueSector)) begin
      data_d.sector = hsv2rgb_pkg::SEC_MAGENTA;
      base          = 15'(5 * hsv2rgb_pkg::HueSector);
    end else if (hue_c >= 15'(4 * hsv2rgb_pkg::HueSector)) begin
      data_d.sector = hsv2rgb_pkg::SEC_BLUE;
      base          = 15'(4 * hsv2rgb_pkg::HueSector);
    end else if (hue_c >= 15'(3 * hsv2rgb_pkg::HueSector)) begin
      data_d.sector = hsv2rgb_pkg::SEC_CYAN;
      base          = 15'(3 * hsv2rgb_pkg::HueSector);
    end else if (hue_c >= 15'(2 * hsv2rgb_pkg::HueSector)) begin
      data_d.sector = hsv2rgb_pkg::SEC_GREEN;
      base          = 15'(2 * hsv2rgb_pkg::HueSector);
    end else if (hue_c >= hsv2rgb_pkg::HueSector) begin
      data_d.sector = hsv2rgb_pkg::SEC_YELLOW;
      base          = hsv2rgb_pkg::HueSector;
    end else begin
      data_d.sector = hsv2rgb_pkg::SEC_RED;
      base          = '0;
    end

    rem_w      = hue_c - base;
    data_d.rem = rem_w[hsv2rgb_pkg::RemW-1:0];

    // saturate s and v at 1.0
    data_d.sat = (sat_i > hsv2rgb_pkg::Unit) ? hsv2rgb_pkg::Unit : sat_i;
    data_d.val = (val_i > hsv2rgb_pkg::Unit) ? hsv2rgb_pkg::Unit : val_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

/* sv/hsv2rgb_scale.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Second and third stages: numerators of q and t, then products with v.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_scale (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  output logic                       ready_o,
  input  wire hsv2rgb_pkg::split_t   data_i,
  output logic                       valid_o,
  input  wire                        ready_i,
  output hsv2rgb_pkg::scaled_t       data_o
);

  localparam int unsigned NumW = hsv2rgb_pkg::NumW;
  localparam int unsigned MulW = hsv2rgb_pkg::MulW;
  localparam int unsigned SvW  = hsv2rgb_pkg::SvW;

  // stage two registers
  logic                          v2_q;
  hsv2rgb_pkg::sector_e          sec2_q;
  logic [NumW-1:0]               num_q_q, num_t_q;
  logic [SvW-1:0]                val2_q;
  logic [hsv2rgb_pkg::VpW-1:0]   vp2_q;
  logic [hsv2rgb_pkg::ChW-1:0]   cv2_q;
  logic                          rdy2;

  // stage three registers
  logic                          v3_q;
  hsv2rgb_pkg::scaled_t          d3_d, d3_q;

  // stage two logic
  logic [hsv2rgb_pkg::RemW-1:0]  rem_c;
  logic [NumW-1:0]               prod_q, prod_t, num_q_d, num_t_d;
  logic [17:0]                   vp_w;
  logic [16:0]                   v255;

  assign ready_o = !v2_q || rdy2;
  assign rdy2    = !v3_q || ready_i;
  assign valid_o = v3_q;
  assign data_o  = d3_q;

  always_comb begin
    rem_c   = hsv2rgb_pkg::HueSector[hsv2rgb_pkg::RemW-1:0] - data_i.rem;
    prod_q  = NumW'(data_i.rem) * NumW'(data_i.sat);
    prod_t  = NumW'(rem_c) * NumW'(data_i.sat);
    num_q_d = hsv2rgb_pkg::FullNum - prod_q;
    num_t_d = hsv2rgb_pkg::FullNum - prod_t;
    vp_w    = 18'(data_i.val) * 18'(hsv2rgb_pkg::Unit - data_i.sat);
    v255    = {data_i.val, 8'd0} - 17'(data_i.val);
  end

  // stage three logic: v times numerators, p channel
  logic [23:0] p255;

  always_comb begin
    p255          = 24'({vp2_q, 8'd0} - 25'(vp2_q));
    d3_d.sector   = sec2_q;
    d3_d.mul_q    = MulW'(MulW'(val2_q) * MulW'(num_q_q));
    d3_d.mul_t    = MulW'(MulW'(val2_q) * MulW'(num_t_q));
    d3_d.ch_v     = cv2_q;
    d3_d.ch_p     = p255[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready_o) begin
        v2_q <= valid_i;
      end
      if (rdy2) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sec2_q  <= data_i.sector;
      num_q_q <= num_q_d;
      num_t_q <= num_t_d;
      val2_q  <= data_i.val;
      vp2_q   <= vp_w[hsv2rgb_pkg::VpW-1:0];
      cv2_q   <= v255[15:8];
    end
    if (rdy2 && v2_q) begin
      d3_q <= d3_d;
    end
  end

endmodule

`default_nettype wire

/* sv/hsv2rgb_mix.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Last stage: final scaling of q and t and the sector permutation.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_mix (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 valid_i,
  output logic                                ready_o,
  input  wire hsv2rgb_pkg::scaled_t           data_i,
  output logic                                valid_o,
  input  wire                                 ready_i,
  output logic [hsv2rgb_pkg::ChW-1:0]         red_o,
  output logic [hsv2rgb_pkg::ChW-1:0]         green_o,
  output logic [hsv2rgb_pkg::ChW-1:0]         blue_o
);

  localparam int unsigned ChW = hsv2rgb_pkg::ChW;

  logic            valid_q;
  logic [ChW-1:0]  red_d, green_d, blue_d;
  logic [ChW-1:0]  red_q, green_q, blue_q;
  logic [32:0]     q17, t17;
  logic [ChW-1:0]  cq, ct;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  always_comb begin
    // 255/(3840*65536) = 17/2^24
    q17 = {1'b0, data_i.mul_q, 4'd0} + 33'(data_i.mul_q);
    t17 = {1'b0, data_i.mul_t, 4'd0} + 33'(data_i.mul_t);
    cq  = q17[31:24];
    ct  = t17[31:24];

    unique case (data_i.sector)
      hsv2rgb_pkg::SEC_RED: begin
        red_d = data_i.ch_v; green_d = ct;          blue_d = data_i.ch_p;
      end
      hsv2rgb_pkg::SEC_YELLOW: begin
        red_d = cq;          green_d = data_i.ch_v; blue_d = data_i.ch_p;
      end
      hsv2rgb_pkg::SEC_GREEN: begin
        red_d = data_i.ch_p; green_d = data_i.ch_v; blue_d = ct;
      end
      hsv2rgb_pkg::SEC_CYAN: begin
        red_d = data_i.ch_p; green_d = cq;          blue_d = data_i.ch_v;
      end
      hsv2rgb_pkg::SEC_BLUE: begin
        red_d = ct;          green_d = data_i.ch_p; blue_d = data_i.ch_v;
      end
      default: begin
        red_d = data_i.ch_v; green_d = data_i.ch_p; blue_d = cq;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

endmodule

`default_nettype wire

/* sv/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Streaming hsv to rgba pixel converter, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// usage
//   hsv_in_i   : sink of hsv beats (hue in 1/64 degree, signed; saturation
//                and brightness with 256 as 1.0, larger values saturate)
//   rgba_out_o : source of rgba beats, 8 bits per channel, alpha fixed at 255
//   a beat moves when valid and ready are both high at a rising edge
// pipeline and throughput
//   four register stages, the first loaded at the edge that accepts an
//   input beat (clamp/sector, numerators, v products, final scale and
//   permutation); one beat per cycle sustained while the output is not
//   stalled, since every stage's ready looks through to the next one
// reset
//   rst_ni clears all stage valid bits at once; no pixel state is kept
// stalls
//   every stage holds its beat while the next one is full and stalled, and
//   takes a new beat as soon as its own slot frees up, so bubbles collapse;
//   hsv_in_i.ready drops only when all four stages hold a pixel
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter (
  input  wire     clk_i,
  input  wire     rst_ni,
  hsv_if.sink     hsv_in_i,
  rgba_if.source  rgba_out_o
);

  // stage one to stage two
  logic                  split_valid;
  logic                  split_ready;
  hsv2rgb_pkg::split_t   split_data;

  // stage three to stage four
  logic                  scale_valid;
  logic                  scale_ready;
  hsv2rgb_pkg::scaled_t  scale_data;

  // clamp and sector split
  hsv2rgb_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hsv_in_i.valid),
    .ready_o (hsv_in_i.ready),
    .hue_i   (hsv_in_i.hue),
    .sat_i   (hsv_in_i.saturation),
    .val_i   (hsv_in_i.brightness),
    .valid_o (split_valid),
    .ready_i (split_ready),
    .data_o  (split_data)
  );

  // numerators and v products, two stages
  hsv2rgb_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .data_i  (split_data),
    .valid_o (scale_valid),
    .ready_i (scale_ready),
    .data_o  (scale_data)
  );

  // final scale and channel permutation, doubles as output register
  hsv2rgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scale_valid),
    .ready_o (scale_ready),
    .data_i  (scale_data),
    .valid_o (rgba_out_o.valid),
    .ready_i (rgba_out_o.ready),
    .red_o   (rgba_out_o.red),
    .green_o (rgba_out_o.green),
    .blue_o  (rgba_out_o.blue)
  );

  assign rgba_out_o.alpha = hsv2rgb_pkg::AlphaOne;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // remainder always lies inside one 60 degree sector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    split_valid |-> (split_data.rem < hsv2rgb_pkg::HueSector[hsv2rgb_pkg::RemW-1:0]))
    else $error("hue remainder out of sector range");

  // input back-pressure only when the pipe is completely full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_in_i.ready |-> (split_valid && scale_valid && rgba_out_o.valid
                         && !rgba_out_o.ready))
    else $error("input stalled while pipeline has a free slot");

  // a stalled stage-three beat is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scale_valid && !scale_ready) |=> (scale_valid && $stable(scale_data)))
    else $error("stalled scale beat changed");

endmodule

`default_nettype wire
